// ===== hdl/rct_pkg.sv =====
`timescale 1ns / 1ps

package rct_pkg;

  // Field widths
  localparam int unsigned ID_W    = 16;
  localparam int unsigned TIME_W  = 64;
  localparam int unsigned KEY_W   = 2 * ID_W;
  localparam int unsigned MSG_W   = 2 * ID_W;
  localparam int unsigned ENT_W   = KEY_W + MSG_W + TIME_W;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned OP_W    = 2;

  // Command codes
  localparam logic [OP_W-1:0] CMD_ALLOC    = 2'd0;
  localparam logic [OP_W-1:0] CMD_COMPLETE = 2'd1;
  localparam logic [OP_W-1:0] CMD_EXPIRE   = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK           = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL         = 3'd1;
  localparam logic [STAT_W-1:0] ST_CLIENT_ZERO  = 3'd2;
  localparam logic [STAT_W-1:0] ST_SERVICE_ZERO = 3'd3;
  localparam logic [STAT_W-1:0] ST_TIMEOUT_ZERO = 3'd4;
  localparam logic [STAT_W-1:0] ST_NOT_PENDING  = 3'd5;
  localparam logic [STAT_W-1:0] ST_MISMATCH     = 3'd6;
  localparam logic [STAT_W-1:0] ST_EXPIRED      = 3'd7;

  // Session counter restarts here and skips zero on wrap
  localparam logic [ID_W-1:0] SESSION_FIRST = 16'd1;

  // Reset value of the capacity limit
  localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

  // Controller to datapath
  typedef struct packed {
    logic latch;    // capture the request
    logic prep;     // early checks, set up the scan
    logic scan_rd;  // issue a table read at the scan index
    logic finish;   // resolve the request, update the table
  } rct_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic early;      // request resolved without a scan
    logic scan_last;  // scan index is at the final entry
  } rct_sts_t;

endpackage

// ===== hdl/rct_ram.sv =====
`timescale 1ns / 1ps

module rct_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/rct_ctrl.sv =====
`timescale 1ns / 1ps

module rct_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  rct_pkg::rct_sts_t sts_i,
  output rct_pkg::rct_cmd_t cmd_o
);
  import rct_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PREP   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_LAST   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;
  localparam logic [2:0] S_RESP   = 3'd5;

  logic [2:0] state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_PREP;
      end
      S_PREP: begin
        state_d = sts_i.early ? S_RESP : S_SCAN;
      end
      S_SCAN: begin
        if (sts_i.scan_last) state_d = S_LAST;
      end
      S_LAST:   state_d = S_FINISH;
      S_FINISH: state_d = S_RESP;
      S_RESP: begin
        if (!out_stall_i) state_d = S_IDLE;
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Handshakes and datapath commands
  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = (state_q == S_RESP);
  assign cmd_o.latch    = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.prep     = (state_q == S_PREP);
  assign cmd_o.scan_rd  = (state_q == S_SCAN);
  assign cmd_o.finish   = (state_q == S_FINISH);

endmodule

// ===== hdl/rct_dpath.sv =====
`timescale 1ns / 1ps

module rct_dpath #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rct_pkg::rct_cmd_t                   cmd_i,
  output rct_pkg::rct_sts_t                   sts_o,
  input  logic                                cfg_we_i,
  input  logic [rct_pkg::CNT_W-1:0]           cfg_data_i,
  input  logic [rct_pkg::OP_W-1:0]            command_i,
  input  logic [rct_pkg::ID_W-1:0]            client_id_i,
  input  logic [rct_pkg::ID_W-1:0]            session_id_i,
  input  logic [rct_pkg::ID_W-1:0]            service_id_i,
  input  logic [rct_pkg::ID_W-1:0]            method_id_i,
  input  logic [rct_pkg::TIME_W-1:0]          now_time_i,
  input  logic [rct_pkg::TIME_W-1:0]          timeout_i,
  output logic [rct_pkg::STAT_W-1:0]          status_o,
  output logic [rct_pkg::ID_W-1:0]            out_client_id_o,
  output logic [rct_pkg::ID_W-1:0]            out_session_id_o,
  output logic [rct_pkg::ID_W-1:0]            out_service_id_o,
  output logic [rct_pkg::ID_W-1:0]            out_method_id_o,
  output logic [rct_pkg::TIME_W-1:0]          out_deadline_o,
  output logic [rct_pkg::CNT_W-1:0]           removed_count_o
);
  import rct_pkg::*;

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

  // Captured request
  logic [OP_W-1:0]   cmd_q;
  logic [ID_W-1:0]   client_q, sess_in_q, service_q, method_q;
  logic [TIME_W-1:0] now_q, tmo_q;
  logic [KEY_W-1:0]  key_q;
  logic [TIME_W-1:0] dl_q;
  logic [MSG_W-1:0]  msg;

  // Table bookkeeping
  logic [ID_W-1:0]        next_sess_q;
  logic [CNT_W-1:0]       count_q, cap_q, removed_q;
  logic [TABLE_DEPTH-1:0] valid_q;

  // Scan state
  logic [IDX_W-1:0]  idx_q, rd_idx_q;
  logic              rd_valid_q;
  logic              found_q, free_q;
  logic [IDX_W-1:0]  found_idx_q, free_idx_q;
  logic [MSG_W-1:0]  found_msg_q;
  logic [TIME_W-1:0] found_dl_q;

  // Result registers
  logic [STAT_W-1:0] status_q, status_d;
  logic [ID_W-1:0]   o_client_q, o_sess_q, o_service_q, o_method_q;
  logic [ID_W-1:0]   o_client_d, o_sess_d, o_service_d, o_method_d;
  logic [TIME_W-1:0] o_dl_q, o_dl_d;
  logic [CNT_W-1:0]  o_removed_q, o_removed_d;

  // Table memory: {key, message, deadline}
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [ENT_W-1:0] ram_wdata, ram_rdata;

  logic [KEY_W-1:0]  rd_key;
  logic [MSG_W-1:0]  rd_msg;
  logic [TIME_W-1:0] rd_dl;
  logic              rd_v, rd_hit, rd_stale;

  logic [CNT_W-1:0]  limit;
  logic              full, early;
  logic [STAT_W-1:0] early_st;
  logic [ID_W-1:0]   sess_inc;

  assign msg = {service_q, method_q};

  // Effective limit is the smaller of the register and the table depth
  always_comb begin
    if ({4'b0, cap_q} < 9'(TABLE_DEPTH)) begin
      limit = cap_q;
    end else begin
      limit = CNT_W'(TABLE_DEPTH);
    end
  end
  assign full = (limit == '0) || (count_q >= limit);

  // Checks that resolve a request without touching the table
  always_comb begin
    early    = 1'b0;
    early_st = ST_OK;
    if (cmd_q == CMD_ALLOC) begin
      early = 1'b1;
      if (full) begin
        early_st = ST_FULL;
      end else if (client_q == '0) begin
        early_st = ST_CLIENT_ZERO;
      end else if (service_q == '0) begin
        early_st = ST_SERVICE_ZERO;
      end else if (tmo_q == '0) begin
        early_st = ST_TIMEOUT_ZERO;
      end else begin
        early = 1'b0;
      end
    end else if (!(cmd_q inside {CMD_COMPLETE, CMD_EXPIRE})) begin
      // unused code: plain ok, no state change
      early = 1'b1;
    end
  end

  assign sts_o.early     = early;
  assign sts_o.scan_last = (idx_q == IDX_LAST);

  // Session counter skips zero
  assign sess_inc = next_sess_q + 1'b1;

  // Scan read data
  assign rd_key   = ram_rdata[ENT_W-1 -: KEY_W];
  assign rd_msg   = ram_rdata[TIME_W +: MSG_W];
  assign rd_dl    = ram_rdata[TIME_W-1:0];
  assign rd_v     = valid_q[rd_idx_q];
  assign rd_hit   = rd_v && (rd_key == key_q);
  assign rd_stale = rd_v && (now_q > rd_dl);

  // Allocate write-back
  assign ram_we    = cmd_i.finish && (cmd_q == CMD_ALLOC) && (found_q || free_q);
  assign ram_waddr = found_q ? found_idx_q : free_idx_q;
  assign ram_wdata = {key_q, msg, dl_q};

  rct_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  // Request capture, key and deadline
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q     <= command_i;
      client_q  <= client_id_i;
      sess_in_q <= session_id_i;
      service_q <= service_id_i;
      method_q  <= method_id_i;
      now_q     <= now_time_i;
      tmo_q     <= timeout_i;
    end
    if (cmd_i.prep) begin
      key_q <= (cmd_q == CMD_ALLOC) ? {client_q, next_sess_q} : {client_q, sess_in_q};
      dl_q  <= now_q + tmo_q;
    end
  end

  // Scan trackers for the matching entry and the lowest free slot
  always_ff @(posedge clk_i) begin
    rd_idx_q <= idx_q;
    if (cmd_i.prep) begin
      idx_q <= '0;
    end else if (cmd_i.scan_rd) begin
      idx_q <= idx_q + 1'b1;
    end
    if (rd_valid_q && rd_hit && !found_q) begin
      found_idx_q <= rd_idx_q;
      found_msg_q <= rd_msg;
      found_dl_q  <= rd_dl;
    end
    if (rd_valid_q && !rd_v && !free_q) begin
      free_idx_q <= rd_idx_q;
    end
  end

  // Control state: flags, counters, valid bits, configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q  <= 1'b0;
      found_q     <= 1'b0;
      free_q      <= 1'b0;
      removed_q   <= '0;
      count_q     <= '0;
      valid_q     <= '0;
      next_sess_q <= SESSION_FIRST;
      cap_q       <= CAP_RESET;
    end else begin
      rd_valid_q <= cmd_i.scan_rd;
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
      if (cmd_i.prep) begin
        found_q   <= 1'b0;
        free_q    <= 1'b0;
        removed_q <= '0;
        if (!early && (cmd_q == CMD_ALLOC)) begin
          next_sess_q <= (sess_inc == '0) ? SESSION_FIRST : sess_inc;
        end
      end
      if (rd_valid_q) begin
        if (rd_hit) found_q <= 1'b1;
        if (!rd_v)  free_q  <= 1'b1;
        // expire pass drops stale entries as they stream past
        if ((cmd_q == CMD_EXPIRE) && rd_stale) begin
          valid_q[rd_idx_q] <= 1'b0;
          removed_q         <= removed_q + 1'b1;
          if (count_q != '0) count_q <= count_q - 1'b1;
        end
      end
      if (cmd_i.finish) begin
        case (cmd_q)
          CMD_ALLOC: begin
            if (!found_q && free_q) begin
              valid_q[free_idx_q] <= 1'b1;
              count_q             <= count_q + 1'b1;
            end
          end
          CMD_COMPLETE: begin
            if (found_q && (found_msg_q == msg)) begin
              valid_q[found_idx_q] <= 1'b0;
              if (count_q != '0) count_q <= count_q - 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Result selection
  always_comb begin
    status_d    = ST_OK;
    o_client_d  = '0;
    o_sess_d    = '0;
    o_service_d = '0;
    o_method_d  = '0;
    o_dl_d      = '0;
    o_removed_d = '0;
    if (cmd_i.prep) begin
      status_d = early_st;
    end else begin
      case (cmd_q)
        CMD_ALLOC: begin
          if (found_q || free_q) begin
            o_client_d  = client_q;
            o_sess_d    = key_q[ID_W-1:0];
            o_service_d = service_q;
            o_method_d  = method_q;
            o_dl_d      = dl_q;
          end else begin
            status_d = ST_FULL;
          end
        end
        CMD_COMPLETE: begin
          if (!found_q) begin
            status_d = ST_NOT_PENDING;
          end else if (found_msg_q != msg) begin
            status_d = ST_MISMATCH;
          end else if (now_q > found_dl_q) begin
            status_d = ST_EXPIRED;
          end else begin
            o_client_d  = key_q[KEY_W-1 -: ID_W];
            o_sess_d    = key_q[ID_W-1:0];
            o_service_d = found_msg_q[MSG_W-1 -: ID_W];
            o_method_d  = found_msg_q[ID_W-1:0];
            o_dl_d      = found_dl_q;
          end
        end
        CMD_EXPIRE: begin
          o_removed_d = removed_q;
        end
        default: ;
      endcase
    end
  end

  // Result registers
  always_ff @(posedge clk_i) begin
    if ((cmd_i.prep && early) || cmd_i.finish) begin
      status_q    <= status_d;
      o_client_q  <= o_client_d;
      o_sess_q    <= o_sess_d;
      o_service_q <= o_service_d;
      o_method_q  <= o_method_d;
      o_dl_q      <= o_dl_d;
      o_removed_q <= o_removed_d;
    end
  end

  assign status_o         = status_q;
  assign out_client_id_o  = o_client_q;
  assign out_session_id_o = o_sess_q;
  assign out_service_id_o = o_service_q;
  assign out_method_id_o  = o_method_q;
  assign out_deadline_o   = o_dl_q;
  assign removed_count_o  = o_removed_q;

endmodule

// ===== hdl/request_correlation_table.sv =====
`timescale 1ns / 1ps
// Flow: a scanned request (allocate, complete, expire) passes prep, a scan over every
//   table entry, a last read and a finish step before its result shows; allocate errors
//   and unused codes resolve in prep and skip the scan. A new request is taken only in
//   idle, once the previous result is taken; the scan reads one table entry per cycle.
// Reset: rst_ni asynchronous, active low; clears all valid bits, the pending count
//   and control state, session counter to 1, capacity limit to 16. No clearing pass.

module request_correlation_table #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [rct_pkg::OP_W-1:0]     command_i,
  input  logic [rct_pkg::ID_W-1:0]     client_id_i,
  input  logic [rct_pkg::ID_W-1:0]     session_id_i,
  input  logic [rct_pkg::ID_W-1:0]     service_id_i,
  input  logic [rct_pkg::ID_W-1:0]     method_id_i,
  input  logic [rct_pkg::TIME_W-1:0]   now_time_i,
  input  logic [rct_pkg::TIME_W-1:0]   timeout_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [rct_pkg::STAT_W-1:0]   status_o,
  output logic [rct_pkg::ID_W-1:0]     out_client_id_o,
  output logic [rct_pkg::ID_W-1:0]     out_session_id_o,
  output logic [rct_pkg::ID_W-1:0]     out_service_id_o,
  output logic [rct_pkg::ID_W-1:0]     out_method_id_o,
  output logic [rct_pkg::TIME_W-1:0]   out_deadline_o,
  output logic [rct_pkg::CNT_W-1:0]    removed_count_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [rct_pkg::CNT_W-1:0]    cfg_data_i
);
  import rct_pkg::*;

  rct_cmd_t cmd;
  rct_sts_t sts;

  // Limit register always takes a write
  assign cfg_ready_o = 1'b1;

  rct_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rct_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_valid_i),
    .cfg_data_i       (cfg_data_i),
    .command_i        (command_i),
    .client_id_i      (client_id_i),
    .session_id_i     (session_id_i),
    .service_id_i     (service_id_i),
    .method_id_i      (method_id_i),
    .now_time_i       (now_time_i),
    .timeout_i        (timeout_i),
    .status_o         (status_o),
    .out_client_id_o  (out_client_id_o),
    .out_session_id_o (out_session_id_o),
    .out_service_id_o (out_service_id_o),
    .out_method_id_o  (out_method_id_o),
    .out_deadline_o   (out_deadline_o),
    .removed_count_o  (removed_count_o)
  );

endmodule

// ===== hdl/rct_checker.sv =====
`timescale 1ns / 1ps

module rct_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [rct_pkg::STAT_W-1:0]   status_o,
  input logic [rct_pkg::ID_W-1:0]     out_client_id_o,
  input logic [rct_pkg::TIME_W-1:0]   out_deadline_o,
  input logic [rct_pkg::CNT_W-1:0]    removed_count_o
);
  import rct_pkg::*;

  // A pending result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // No new request is taken while a result waits
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("request accepted with a result outstanding");

  // A result never appears in the cycle right after acceptance
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !out_valid_o)
    else $error("result too early");

  // A full result carries no entry
  a_full_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL) |->
      (out_client_id_o == '0) && (out_deadline_o == '0) && (removed_count_o == '0))
    else $error("full result carries entry data");

endmodule

bind request_correlation_table rct_checker u_rct_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .status_o        (status_o),
  .out_client_id_o (out_client_id_o),
  .out_deadline_o  (out_deadline_o),
  .removed_count_o (removed_count_o)
);
